/* design/tpcb_pkg.sv */
// Shared types and constants for the threshold promote cache buffer.
// Used by tpcb_cell and threshold_promote_cache_buffer; depends on nothing.
package tpcb_pkg;

  // Default sizes for the top-level parameters
  localparam int DEPTH_DEFAULT      = 16;
  localparam int KEY_BITS_DEFAULT   = 64;
  localparam int COUNT_BITS_DEFAULT = 16;

  // Fixed port widths
  localparam int KEY_PORT_W   = 64;
  localparam int POS_PORT_W   = 4;
  localparam int COUNT_PORT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int THRESH_W     = 16;
  localparam int CAP_W        = 5;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_PROMOTE_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY_IN_USE   = 1'd1;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd2;
  localparam logic [CAP_W-1:0]    CAPACITY_RESET  = 5'd16;

  // Input commands
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Per-cell control from the update stage
  typedef struct packed {
    logic shift;       // take key and count from the left neighbor
    logic load_count;  // take the updated hit count in place
  } cell_ctrl_t;

endpackage

/* design/tpcb_cell.sv */
// One cache entry of the chain: key and hit counter, with its key compare.
// Depends on tpcb_pkg for the control struct.
module tpcb_cell #(
  parameter int KEY_BITS   = tpcb_pkg::KEY_BITS_DEFAULT,
  parameter int COUNT_BITS = tpcb_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                    clk,
  input  tpcb_pkg::cell_ctrl_t    ctrl,
  input  logic                    valid,
  input  logic [KEY_BITS-1:0]     req_key,
  input  logic [KEY_BITS-1:0]     prev_key,
  input  logic [COUNT_BITS-1:0]   prev_count,
  input  logic [COUNT_BITS-1:0]   upd_count,
  output logic [KEY_BITS-1:0]     key,
  output logic [COUNT_BITS-1:0]   count,
  output logic                    match
);

  // Compare the held key against the request
  assign match = valid && (key == req_key);

  // Shift from the neighbor, or update the counter in place
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key   <= prev_key;
      count <= prev_count;
    end else if (ctrl.load_count) begin
      count <= upd_count;
    end
  end

endmodule

/* design/threshold_promote_cache_buffer.sv */
// Move-to-front cache of page keys with a hit-count promotion threshold.
// Top level: a chain of tpcb_cell entries, control, config and result registers.
// Depends on tpcb_pkg and tpcb_cell.
//
// Each request or clear passes through a compare state, in which every cell
// compares its key against the request in parallel, and an update state, in
// which the chain shifts one place (or a counter updates) and the result is
// loaded into the output register. The next item is accepted in the update
// state, so the block takes a new item as it finishes the last one while
// out_ready stays high; a result that is not taken holds the update state.
// Configuration writes take effect at once and belong between items.
module threshold_promote_cache_buffer #(
  parameter int DEPTH      = tpcb_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS   = tpcb_pkg::KEY_BITS_DEFAULT,
  parameter int COUNT_BITS = tpcb_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [tpcb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tpcb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [tpcb_pkg::KEY_PORT_W-1:0]     page_key,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [tpcb_pkg::POS_PORT_W-1:0]     hit_position,
  output logic [tpcb_pkg::COUNT_PORT_W-1:0]   new_count,
  output logic                                promoted,
  output logic                                evicted,
  output logic [tpcb_pkg::KEY_PORT_W-1:0]     evicted_key
);

  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW  = $clog2(DEPTH + 1);
  localparam int CXW = 9;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration registers
  logic [tpcb_pkg::THRESH_W-1:0] promote_threshold;
  logic [tpcb_pkg::CAP_W-1:0]    capacity_in_use;

  // request registers
  logic                cmd_q;
  logic [KEY_BITS-1:0] key_q;

  // compare-stage registers
  logic [DEPTH-1:0]      match_q;
  logic                  hit_q;
  logic [IW-1:0]         pos_q;
  logic [COUNT_BITS-1:0] mcount_q;
  logic [KEY_BITS-1:0]   last_key_q;

  logic [OW-1:0] occupancy;

  // chain wiring
  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [COUNT_BITS-1:0] cell_count [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_last;
  tpcb_pkg::cell_ctrl_t  cell_ctrl  [DEPTH];

  logic                  in_xfer;
  logic                  out_free;
  logic                  commit;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] ins_count;
  logic                  do_promote;
  logic                  do_evict;
  logic [CXW-1:0]        cap_x;
  logic [OW-1:0]         cap_eff;
  logic [IW-1:0]         pos_c;
  logic [COUNT_BITS-1:0] mcount_c;
  logic [KEY_BITS-1:0]   last_key_c;

  assign out_free = !out_valid || out_ready;
  assign commit   = (state == ST_UPD) && out_free;
  assign in_ready = (state == ST_IDLE) || commit;
  assign in_xfer  = in_valid && in_ready;

  // sequence: accept, compare, update
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (commit) state_next = in_xfer ? ST_CMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      promote_threshold <= tpcb_pkg::THRESHOLD_RESET;
      capacity_in_use   <= tpcb_pkg::CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpcb_pkg::REG_PROMOTE_THRESHOLD: promote_threshold <= cfg_data;
        tpcb_pkg::REG_CAPACITY_IN_USE:   capacity_in_use <= cfg_data[tpcb_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the accepted request
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q <= cmd;
      key_q <= page_key[KEY_BITS-1:0];
    end
  end

  // per-cell occupancy and last-entry flags
  for (genvar i = 0; i < DEPTH; i++) begin : g_flags
    assign cell_valid[i] = OW'(i) < occupancy;
    assign cell_last[i]  = OW'(i + 1) == occupancy;
  end

  // fold the one-hot match into position, count and the last key
  always_comb begin
    pos_c      = '0;
    mcount_c   = '0;
    last_key_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i]) begin
        pos_c    = pos_c | IW'(i);
        mcount_c = mcount_c | cell_count[i];
      end
      if (cell_last[i]) begin
        last_key_c = last_key_c | cell_key[i];
      end
    end
  end

  // register compare results
  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      match_q    <= cell_match;
      hit_q      <= |cell_match;
      pos_q      <= pos_c;
      mcount_q   <= mcount_c;
      last_key_q <= last_key_c;
    end
  end

  // update decisions
  assign cnt_inc    = (mcount_q == {COUNT_BITS{1'b1}}) ? mcount_q : mcount_q + 1'b1;
  assign do_promote = hit_q && (32'(cnt_inc) > 32'(promote_threshold)) && (pos_q != '0);
  assign ins_count  = hit_q ? cnt_inc : COUNT_BITS'(1);
  assign cap_x      = CXW'(capacity_in_use);
  assign cap_eff    = (cap_x == '0) ? OW'(1) :
                      (cap_x > CXW'(DEPTH)) ? OW'(DEPTH) : OW'(cap_x);
  assign do_evict   = !hit_q && (occupancy >= cap_eff);

  // drive the chain controls
  for (genvar i = 0; i < DEPTH; i++) begin : g_ctrl
    assign cell_ctrl[i].shift = commit && (cmd_q == tpcb_pkg::CMD_REQUEST) &&
                                (!hit_q || (do_promote && (IW'(i) <= pos_q)));
    assign cell_ctrl[i].load_count = commit && (cmd_q == tpcb_pkg::CMD_REQUEST) &&
                                     hit_q && !do_promote && match_q[i];
  end

  // chain of entries, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_front
      tpcb_cell #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .valid      (cell_valid[i]),
        .req_key    (key_q),
        .prev_key   (key_q),
        .prev_count (ins_count),
        .upd_count  (cnt_inc),
        .key        (cell_key[i]),
        .count      (cell_count[i]),
        .match      (cell_match[i])
      );
    end else begin : g_rest
      tpcb_cell #(.KEY_BITS(KEY_BITS), .COUNT_BITS(COUNT_BITS)) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .valid      (cell_valid[i]),
        .req_key    (key_q),
        .prev_key   (cell_key[i-1]),
        .prev_count (cell_count[i-1]),
        .upd_count  (cnt_inc),
        .key        (cell_key[i]),
        .count      (cell_count[i]),
        .match      (cell_match[i])
      );
    end
  end

  // occupancy: clear, insert, or trim to capacity on a full miss
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (commit) begin
      if (cmd_q == tpcb_pkg::CMD_CLEAR) begin
        occupancy <= '0;
      end else if (!hit_q) begin
        occupancy <= do_evict ? cap_eff : occupancy + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (cmd_q == tpcb_pkg::CMD_CLEAR) begin
        hit          <= 1'b0;
        hit_position <= '0;
        new_count    <= '0;
        promoted     <= 1'b0;
        evicted      <= 1'b0;
        evicted_key  <= '0;
      end else begin
        hit          <= hit_q;
        hit_position <= hit_q ? tpcb_pkg::POS_PORT_W'(pos_q) : '0;
        new_count    <= tpcb_pkg::COUNT_PORT_W'(ins_count);
        promoted     <= do_promote;
        evicted      <= do_evict;
        evicted_key  <= do_evict ? tpcb_pkg::KEY_PORT_W'(last_key_q) : '0;
      end
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OW'(DEPTH))
    else $error("occupancy beyond depth");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(match_q))
    else $error("key held in more than one entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (commit && (cmd_q == tpcb_pkg::CMD_CLEAR)) |=> (occupancy == '0))
    else $error("clear left entries");

  a_promote_on_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && promoted) |-> (hit && !evicted && (hit_position != '0)))
    else $error("promotion without a hit behind the front");

  a_miss_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && (cmd_q == tpcb_pkg::CMD_REQUEST) && !hit_q && !do_evict)
      |=> (occupancy == $past(occupancy) + 1'b1))
    else $error("miss did not add an entry");

endmodule
